// ===== hdl/sxb62_pkg.sv =====
// ----------------------------------------------------------------------------
// sxb62_pkg
// Shared types, constants and the digit-to-ASCII map of the base62 encoder.
// ----------------------------------------------------------------------------
package sxb62_pkg;

  localparam int HASH_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int CHAR_W      = 7;
  localparam int DIGIT_W     = 6;
  localparam int B62_RADIX   = 62;
  localparam int HASH_SHIFT  = 5;
  localparam int MAX_DIGITS  = 6;
  localparam int DCNT_W      = 3;

  // Rounded-up reciprocal of 31 scaled by 2^36; exact for any 31-bit operand.
  localparam int                 RECIP_W     = 32;
  localparam logic [RECIP_W-1:0] RECIP_M     = 32'd2216757315;
  localparam int                 RECIP_SHIFT = 36;
  localparam int                 PROD_W      = HASH_W - 1 + RECIP_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } sxb62_state_t;

  // Status of the shared divide unit, seen by the sequencer.
  typedef struct packed {
    logic done;
    logic quot_zero;
  } div_sts_t;

  // Digits 0-9 map to '0'-'9', 10-35 to 'A'-'Z', 36-61 to 'a'-'z'.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(10)) begin
      c = CHAR_W'(48) + CHAR_W'(d);
    end else if (d < DIGIT_W'(36)) begin
      c = CHAR_W'(55) + CHAR_W'(d);
    end else begin
      c = CHAR_W'(61) + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

// ===== hdl/shift_xor_hash_base62_encoder.sv =====
// ----------------------------------------------------------------------------
// shift_xor_hash_base62_encoder
// Shift-add-xor text hash with base62 ASCII output of the finished hash.
// ----------------------------------------------------------------------------
// Text bytes enter on the in_ stream, one item per byte. in_tuser set means
// in_tdata holds a byte, which is sign-extended and folded into the hash as
// h = (h << 5) + (h ^ byte). in_tlast marks the final item of a text; it may
// carry a byte or not. Byte items are taken at one per cycle while the block
// is idle, with in_tready high.
// On the final item the hash is converted to base62 by a shared divide-by-62
// unit built on one reciprocal multiply, giving 1 to 6 digits; in_tready
// stays low while the digits are formed and the characters are emitted.
// Characters then leave on the out_ stream most significant first, one per
// cycle while out_tready is high; out_tlast marks the last one, and every
// character carries the finished hash. The block takes the next text item as
// soon as the last character sits in the output register.
// A stall on out_ holds the output register and stops emission; nothing is
// dropped. Reset clears the hash, the sequencer and the output valid.
// ----------------------------------------------------------------------------
module shift_xor_hash_base62_encoder import sxb62_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tuser,   // [0] carries_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [6:0] char_code, [38:7] hash_value, [39] zero
  output logic        out_tlast   // last_char
);

  sxb62_state_t        state_r, state_nxt;
  logic [HASH_W-1:0]   hash_r, hash_nxt;
  logic [HASH_W-1:0]   hash_fin_r, hash_fin_nxt;
  logic [DCNT_W-1:0]   ndig_r, ndig_nxt;
  logic [DCNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [DIGIT_W-1:0]  dig_mem [MAX_DIGITS];
  logic                dig_we;
  logic                char_ld;
  logic                out_valid_r, out_valid_nxt;
  logic                out_last_r, out_last_nxt;
  logic [CHAR_W-1:0]   out_char_r;
  logic [HASH_W-1:0]   out_hash_r, out_hash_nxt;

  logic                div_start;
  logic [HASH_W-1:0]   div_dividend;
  logic [HASH_W-1:0]   div_quo;
  logic [DIGIT_W-1:0]  div_rem;
  div_sts_t            div_sts;

  logic                in_fire;
  logic [HASH_W-1:0]   byte_sext;
  logic [HASH_W-1:0]   hash_upd;
  logic                load_ok;

  sxb62_div62 u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .quotient  (div_quo),
    .remainder (div_rem),
    .sts       (div_sts)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign byte_sext = {{(HASH_W-BYTE_W){in_tdata[BYTE_W-1]}}, in_tdata};
  assign hash_upd  = in_tuser ? ((hash_r << HASH_SHIFT) + (hash_r ^ byte_sext)) : hash_r;
  assign load_ok   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    hash_nxt      = hash_r;
    hash_fin_nxt  = hash_fin_r;
    ndig_nxt      = ndig_r;
    rd_idx_nxt    = rd_idx_r;
    dig_we        = 1'b0;
    char_ld       = 1'b0;
    div_start     = 1'b0;
    div_dividend  = div_quo;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    out_hash_nxt  = out_hash_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tlast) begin
            hash_nxt     = '0;
            hash_fin_nxt = hash_upd;
            ndig_nxt     = '0;
            div_start    = 1'b1;
            div_dividend = hash_upd;
            state_nxt    = ST_DIV;
          end else begin
            hash_nxt = hash_upd;
          end
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          dig_we   = 1'b1;
          ndig_nxt = ndig_r + DCNT_W'(1);
          if (div_sts.quot_zero || ndig_r == DCNT_W'(MAX_DIGITS-1)) begin
            rd_idx_nxt = ndig_r;
            state_nxt  = ST_EMIT;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        // Digits were stored least significant first; read them back downward.
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          char_ld       = 1'b1;
          out_last_nxt  = (rd_idx_r == '0);
          out_hash_nxt  = hash_fin_r;
          if (rd_idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r - DCNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hash_r      <= '0;
      ndig_r      <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      ndig_r      <= ndig_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hash_fin_r <= hash_fin_nxt;
    out_last_r <= out_last_nxt;
    out_hash_r <= out_hash_nxt;
    if (char_ld) begin
      out_char_r <= digit_char(dig_mem[rd_idx_r]);
    end
    if (dig_we) begin
      dig_mem[ndig_r] <= div_rem;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_hash_r, out_char_r};

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> state_r == ST_DIV)
    else $error("divide unit finished outside the digit phase");

  a_rd_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> rd_idx_r < ndig_r)
    else $error("emit index beyond stored digits");

  a_more_chars: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |-> state_r == ST_EMIT)
    else $error("non-final character taken with no character pending");

  a_end_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (state_r == ST_DIV && hash_r == '0))
    else $error("end item did not start digit conversion");
`endif

endmodule

// ===== hdl/sxb62_div62.sv =====
// ----------------------------------------------------------------------------
// sxb62_div62
// Divide-by-62 unit: one reciprocal multiply; start loads the dividend register,
// then the quotient register and the done flag are loaded from the product.
// ----------------------------------------------------------------------------
module sxb62_div62 import sxb62_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [HASH_W-1:0]   dividend,
  output logic [HASH_W-1:0]   quotient,
  output logic [DIGIT_W-1:0]  remainder,
  output div_sts_t            sts
);

  logic [HASH_W-1:0]  num_r, num_nxt;
  logic [HASH_W-1:0]  quo_r, quo_nxt;
  logic               run_r, run_nxt;
  logic               done_r, done_nxt;
  logic [PROD_W-1:0]  prod;

  // x / 62 equals (x >> 1) / 31, taken as a multiply by the scaled reciprocal.
  assign prod = PROD_W'(num_r[HASH_W-1:1]) * PROD_W'(RECIP_M);

  always_comb begin
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    run_nxt  = 1'b0;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt = dividend;
      run_nxt = 1'b1;
    end else if (run_r) begin
      quo_nxt  = HASH_W'(prod[PROD_W-1:RECIP_SHIFT]);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    quo_r <= quo_nxt;
  end

  // The remainder is below 64, so x - 62*q is formed modulo 64, where -62 is +2.
  assign quotient      = quo_r;
  assign remainder     = num_r[DIGIT_W-1:0] + {quo_r[DIGIT_W-2:0], 1'b0};
  assign sts.done      = done_r;
  assign sts.quot_zero = (quo_r == '0);

endmodule
